// ===== hdl/hjb_pkg.sv =====
package hjb_pkg;

  localparam int unsigned MaxBuckets = 1024;
  localparam int unsigned MaxEntries = 64;
  localparam int unsigned BktW       = $clog2(MaxBuckets);
  localparam int unsigned EntW       = $clog2(MaxEntries);
  localparam int unsigned PtrW       = EntW + 1;
  localparam int unsigned CfgW       = 11;
  localparam int unsigned KeyW       = 32;
  localparam int unsigned WordW      = 64;
  localparam int unsigned DivCntW    = $clog2(KeyW);
  localparam logic [KeyW-1:0] HashMult = 32'd2654435761;

  typedef enum logic [1:0] {
    StInserted = 2'd0,
    StFull     = 2'd1,
    StMatch    = 2'd2,
    StNoMatch  = 2'd3
  } hjb_status_e;

  typedef enum logic [1:0] {
    OselIns,
    OselFull,
    OselPend,
    OselNoMatch
  } hjb_osel_e;

  typedef enum logic [3:0] {
    SClear,
    SIdle,
    SMul,
    SDivStart,
    SDiv,
    SHeadRd,
    SBranch,
    SBuild,
    SWalk,
    SEntWait
  } hjb_state_e;

  typedef struct packed {
    logic      clr_step;
    logic      in_load;
    logic      mul_go;
    logic      div_start;
    logic      head_rd;
    logic      build_commit;
    logic      walk_init;
    logic      ent_rd;
    logic      walk_adv;
    logic      out_load;
    hjb_osel_e out_sel;
    logic      out_last;
  } hjb_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic is_probe;
    logic full;
    logic walk_end;
    logic key_eq;
    logic pend_v;
    logic out_free;
  } hjb_stat_t;

endpackage

// ===== hdl/hash_join_build_probe.sv =====
// hash-join build and probe engine over a 64-entry store of keyed 8-byte words.
// a build request (tuser 0) puts its key and word at the head of bucket
// ((key * 2654435761) mod 2^32) mod bucket_total and answers inserted, or full
// once the store is used up; a probe request (tuser 1) walks that chain newest
// first and gives one match result per equal key, or one no-match result, the
// final one with tlast set. after reset a clearing sweep of the bucket heads
// runs, during which no request is taken. the hash remainder unit works one
// bit a cycle over 32 bits, and the chain walk reads the entry store through
// a register. the user must write bucket_total through the cfg port only
// while the block is idle; the block itself does not enforce this
module hash_join_build_probe
  import hjb_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  // bucket_total register
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [10:0]   cfg_data_i,
  // requests in
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [95:0]   s_axis_tdata,  // join_key [31:0], row_word [95:32]
  input  logic [0:0]    s_axis_tuser,  // req_type
  // results out
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [159:0]  m_axis_tdata,  // match_key [31:0], stored_word [95:32],
                                       // probe_word [159:96]
  output logic [1:0]    m_axis_tuser,  // status
  output logic          m_axis_tlast
);

  hjb_cmd_t  cmd;
  hjb_stat_t stat;

  // config is always taken
  assign cfg_ready_o = 1'b1;

  // sequencer
  hjb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // hash, stores, chain walk and result register
  hjb_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_type_i    (s_axis_tuser[0]),
    .in_key_i     (s_axis_tdata[31:0]),
    .in_word_i    (s_axis_tdata[95:32]),
    .cfg_we_i     (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (m_axis_tuser),
    .out_key_o    (m_axis_tdata[31:0]),
    .out_stored_o (m_axis_tdata[95:32]),
    .out_probe_o  (m_axis_tdata[159:96]),
    .out_last_o   (m_axis_tlast)
  );

endmodule

// ===== hdl/hjb_mod.sv =====
module hjb_mod
  import hjb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [KeyW-1:0]     dividend_i,
  input  logic [CfgW-1:0]     modulus_i,
  output logic [BktW-1:0]     rem_o,
  output logic                done_o
);

  logic [KeyW-1:0]    shf_q, shf_d;
  logic [BktW-1:0]    rem_q, rem_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CfgW-1:0]    trial;

  // one quotient bit a cycle, remainder stays below the modulus
  always_comb begin
    trial  = {rem_q, shf_q[KeyW-1]};
    shf_d  = shf_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      shf_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= modulus_i) begin
        rem_d = BktW'(trial - modulus_i);
      end else begin
        rem_d = BktW'(trial);
      end
      shf_d = {shf_q[KeyW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (&cnt_q) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shf_q <= shf_d;
    rem_q <= rem_d;
  end

  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

// ===== hdl/hjb_ctrl.sv =====
module hjb_ctrl
  import hjb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  hjb_stat_t stat_i,
  output hjb_cmd_t  cmd_o
);

  hjb_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.out_sel = OselIns;
    in_ready_o = 1'b0;
    unique case (state_q)
      SClear: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) state_d = SIdle;
      end
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = SMul;
        end
      end
      SMul: begin
        cmd_o.mul_go = 1'b1;
        state_d      = SDivStart;
      end
      SDivStart: begin
        cmd_o.div_start = 1'b1;
        state_d         = SDiv;
      end
      SDiv: begin
        if (stat_i.div_done) state_d = SHeadRd;
      end
      SHeadRd: begin
        cmd_o.head_rd = 1'b1;
        state_d       = SBranch;
      end
      SBranch: begin
        if (stat_i.is_probe) begin
          cmd_o.walk_init = 1'b1;
          state_d         = SWalk;
        end else begin
          state_d = SBuild;
        end
      end
      SBuild: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = 1'b1;
          if (stat_i.full) begin
            cmd_o.out_sel = OselFull;
          end else begin
            cmd_o.out_sel      = OselIns;
            cmd_o.build_commit = 1'b1;
          end
          state_d = SIdle;
        end
      end
      SWalk: begin
        if (stat_i.walk_end) begin
          if (stat_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_last = 1'b1;
            cmd_o.out_sel  = stat_i.pend_v ? OselPend : OselNoMatch;
            state_d        = SIdle;
          end
        end else begin
          cmd_o.ent_rd = 1'b1;
          state_d      = SEntWait;
        end
      end
      SEntWait: begin
        if (stat_i.key_eq && stat_i.pend_v) begin
          if (stat_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_sel  = OselPend;
            cmd_o.walk_adv = 1'b1;
            state_d        = SWalk;
          end
        end else begin
          cmd_o.walk_adv = 1'b1;
          state_d        = SWalk;
        end
      end
      default: state_d = SIdle;
    endcase
  end

endmodule

// ===== hdl/hjb_datapath.sv =====
module hjb_datapath
  import hjb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hjb_cmd_t             cmd_i,
  output hjb_stat_t            stat_o,
  input  logic                 in_type_i,
  input  logic [KeyW-1:0]      in_key_i,
  input  logic [WordW-1:0]     in_word_i,
  input  logic                 cfg_we_i,
  input  logic [CfgW-1:0]      cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           out_status_o,
  output logic [KeyW-1:0]      out_key_o,
  output logic [WordW-1:0]     out_stored_o,
  output logic [WordW-1:0]     out_probe_o,
  output logic                 out_last_o
);

  logic [CfgW-1:0]  bc_q;
  logic [CfgW-1:0]  modulus;
  logic             type_q;
  logic [KeyW-1:0]  key_q;
  logic [WordW-1:0] word_q;
  logic [KeyW-1:0]  prod_q;
  logic [BktW-1:0]  bkt;
  logic             div_done;

  logic [PtrW-1:0]  heads [MaxBuckets];
  logic [PtrW-1:0]  head_q;
  logic [BktW-1:0]  clr_cnt_q;

  logic [KeyW-1:0]  ent_keys  [MaxEntries];
  logic [WordW-1:0] ent_words [MaxEntries];
  logic [PtrW-1:0]  ent_links [MaxEntries];
  logic [KeyW-1:0]  ek_q;
  logic [WordW-1:0] ew_q;
  logic [PtrW-1:0]  el_q;

  logic [PtrW-1:0]  used_q;
  logic [PtrW-1:0]  ptr_q;
  logic [PtrW-1:0]  ptr_m1;
  logic [PtrW-1:0]  steps_q;
  logic             pend_v_q;
  logic [WordW-1:0] pend_q;
  logic             out_valid_q;
  logic             key_eq;

  // effective modulus: zero counts as one, clamp to the bucket store
  always_comb begin
    if (bc_q == '0) begin
      modulus = CfgW'(1);
    end else if (bc_q > CfgW'(MaxBuckets)) begin
      modulus = CfgW'(MaxBuckets);
    end else begin
      modulus = bc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q <= CfgW'(MaxBuckets);
    end else if (cfg_we_i) begin
      bc_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      type_q <= in_type_i;
      key_q  <= in_key_i;
      word_q <= in_word_i;
    end
    if (cmd_i.mul_go) begin
      prod_q <= KeyW'(key_q * HashMult);
    end
  end

  hjb_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_q),
    .modulus_i  (modulus),
    .rem_o      (bkt),
    .done_o     (div_done)
  );

  // bucket heads memory, cleared by a sweep after reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      heads[clr_cnt_q] <= '0;
    end else if (cmd_i.build_commit) begin
      heads[bkt] <= used_q + 1'b1;
    end
    if (cmd_i.head_rd) begin
      head_q <= heads[bkt];
    end
  end

  assign ptr_m1 = ptr_q - 1'b1;

  // entry store
  always_ff @(posedge clk_i) begin
    if (cmd_i.build_commit) begin
      ent_keys[used_q[EntW-1:0]]  <= key_q;
      ent_words[used_q[EntW-1:0]] <= word_q;
      ent_links[used_q[EntW-1:0]] <= head_q;
    end
    if (cmd_i.ent_rd) begin
      ek_q <= ent_keys[ptr_m1[EntW-1:0]];
      ew_q <= ent_words[ptr_m1[EntW-1:0]];
      el_q <= ent_links[ptr_m1[EntW-1:0]];
    end
  end

  assign key_eq = (ek_q == key_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      used_q      <= '0;
      ptr_q       <= '0;
      steps_q     <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cmd_i.build_commit) used_q <= used_q + 1'b1;
      if (cmd_i.walk_init) begin
        ptr_q    <= head_q;
        steps_q  <= '0;
        pend_v_q <= 1'b0;
      end else if (cmd_i.walk_adv) begin
        ptr_q   <= el_q;
        steps_q <= steps_q + 1'b1;
        if (key_eq) pend_v_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_adv && key_eq) begin
      pend_q <= ew_q;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_key_o  <= key_q;
      out_last_o <= cmd_i.out_last;
      case (cmd_i.out_sel)
        OselIns: begin
          out_status_o <= StInserted;
          out_stored_o <= word_q;
          out_probe_o  <= '0;
        end
        OselFull: begin
          out_status_o <= StFull;
          out_stored_o <= '0;
          out_probe_o  <= '0;
        end
        OselPend: begin
          out_status_o <= StMatch;
          out_stored_o <= pend_q;
          out_probe_o  <= word_q;
        end
        default: begin
          out_status_o <= StNoMatch;
          out_stored_o <= '0;
          out_probe_o  <= word_q;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stat_o.clr_last = &clr_cnt_q;
  assign stat_o.div_done = div_done;
  assign stat_o.is_probe = type_q;
  assign stat_o.full     = (used_q == PtrW'(MaxEntries));
  assign stat_o.walk_end = (ptr_q == '0) || (ptr_q > PtrW'(MaxEntries))
                           || (steps_q == PtrW'(MaxEntries));
  assign stat_o.key_eq   = key_eq;
  assign stat_o.pend_v   = pend_v_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import hjb_pkg::*;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned SettleCycles = 200;

  typedef struct {
    hjb_status_e   status;
    logic [31:0]   key;
    logic [63:0]   stored;
    logic [63:0]   probe;
    logic          last;
  } join_result_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic [10:0]   cfg_data_i = '0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [95:0]   s_axis_tdata = '0;   // join_key [31:0], row_word [95:32]
  logic [0:0]    s_axis_tuser = '0;   // req_type
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [159:0]  m_axis_tdata;        // match_key [31:0], stored_word [95:32],
                                      // probe_word [159:96]
  logic [1:0]    m_axis_tuser;        // status
  logic          m_axis_tlast;

  // predictor copy of the block state
  logic [10:0]   bucket_reg;
  logic [6:0]    heads [MaxBuckets];
  logic [31:0]   stored_keys [MaxEntries];
  logic [63:0]   stored_words [MaxEntries];
  logic [6:0]    stored_links [MaxEntries];
  int unsigned   rows_used;

  join_result_t  pending_results[$];
  int unsigned   errors;
  int unsigned   cycles;
  int unsigned   n_builds, n_probes, n_matches, n_full, n_nomatch, n_cfg;
  bit            hold_req;
  int unsigned   hold_left;
  int unsigned   stall_left;

  hash_join_build_probe u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  // watchdog, counted from the start so the clearing sweep is included
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[hash_join_build_probe] ERROR");
      $finish;
    end
  end

  // gap length: mostly none or short, now and then long
  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // multiplicative hash folded onto the buckets in use
  function automatic int unsigned hash_bucket(logic [31:0] key);
    logic [31:0] h;
    int unsigned modulus;
    h = key * HashMult;
    modulus = bucket_reg;
    if (modulus == 0) modulus = 1;
    if (modulus > MaxBuckets) modulus = MaxBuckets;
    return h % modulus;
  endfunction

  // works out the results of one accepted request and updates the store
  task automatic join_predict(logic is_probe, logic [31:0] key, logic [63:0] word);
    int unsigned b;
    int unsigned ptr;
    int unsigned steps;
    int unsigned found;
    join_result_t res;
    b = hash_bucket(key);
    if (!is_probe) begin
      n_builds++;
      res.key = key; res.probe = '0; res.last = 1'b1;
      if (rows_used >= MaxEntries) begin
        res.status = StFull; res.stored = '0;
        n_full++;
      end else begin
        stored_keys[rows_used]  = key;
        stored_words[rows_used] = word;
        stored_links[rows_used] = heads[b];
        heads[b] = 7'(rows_used + 1);
        rows_used++;
        res.status = StInserted; res.stored = word;
      end
      pending_results.push_back(res);
      return;
    end
    n_probes++;
    found = 0;
    ptr = heads[b];
    steps = 0;
    // newest first, never more than the store holds
    while (ptr != 0 && steps < MaxEntries) begin
      if (stored_keys[ptr-1] == key) begin
        res.status = StMatch; res.key = key; res.stored = stored_words[ptr-1];
        res.probe = word; res.last = 1'b0;
        pending_results.push_back(res);
        found++;
      end
      ptr = stored_links[ptr-1];
      steps++;
    end
    if (found == 0) begin
      res.status = StNoMatch; res.key = key; res.stored = '0;
      res.probe = word; res.last = 1'b1;
      pending_results.push_back(res);
      n_nomatch++;
    end else begin
      pending_results[pending_results.size()-1].last = 1'b1;
      n_matches += found;
    end
  endtask

  // one request: optional gap, then hold it until the handshake
  task automatic send_request(logic is_probe, logic [31:0] key, logic [63:0] word,
                              int unsigned gap);
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= is_probe;
    s_axis_tdata  <= {word, key};
    do @(posedge clk_i); while (!s_axis_tready);
    join_predict(is_probe, key, word);
  endtask

  task automatic end_requests();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  // wait for every expected result, then let the pipeline settle
  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // bucket_total write, issued with no request in flight (the first one during the clearing sweep)
  task automatic write_buckets(logic [10:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    bucket_reg = value;
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // small key pool so chains repeat keys, otherwise any 32-bit key
  function automatic logic [31:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      4, 5: return 32'($urandom_range(1, 6));
      default: return $urandom();
    endcase
  endfunction

  // result side: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req <= 1'b0;
      hold_left <= 400;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      stall_left <= rand_gap();
      m_axis_tready <= 1'b1;
    end
  end

  // result checker, field by field against the oldest expectation
  always @(posedge clk_i) begin
    join_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status %0d key %h", $time, m_axis_tuser,
                 m_axis_tdata[31:0]);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[31:0] !== want.key) begin
          $display("%0t: match_key exp %h got %h", $time, want.key, m_axis_tdata[31:0]);
          errors++;
        end
        if (m_axis_tdata[95:32] !== want.stored) begin
          $display("%0t: stored_word exp %h got %h", $time, want.stored,
                   m_axis_tdata[95:32]);
          errors++;
        end
        if (m_axis_tdata[159:96] !== want.probe) begin
          $display("%0t: probe_word exp %h got %h", $time, want.probe,
                   m_axis_tdata[159:96]);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: last exp %0b got %0b", $time, want.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // extremes of key and word, one bucket (count 0), repeated keys, misses
  task automatic test_directed();
    write_buckets(11'd0);
    send_request(1'b0, 32'd5, 64'h0000_0000_0000_0001, 0);
    send_request(1'b0, 32'h8000_0000, 64'hffff_ffff_ffff_ffff, 0);
    send_request(1'b0, 32'h7fff_ffff, 64'd0, 0);
    send_request(1'b0, 32'd5, 64'h6f6c_6c65_68, 0);
    send_request(1'b0, 32'hffff_ffff, 64'h8000_0000_0000_0000, 0);
    send_request(1'b0, 32'd5, 64'h0123_4567_89ab_cdef, 0);
    send_request(1'b1, 32'd5, 64'haaaa_5555_aaaa_5555, 0);      // three matches
    send_request(1'b1, 32'd7, 64'hffff_ffff_ffff_ffff, 0);      // no match
    send_request(1'b1, 32'h8000_0000, 64'd0, 0);
    send_request(1'b1, 32'h7fff_ffff, 64'h5555_aaaa_5555_aaaa, 0);
    send_request(1'b1, 32'hffff_ffff, 64'd1, 0);
    end_requests();
    drain();
    // above the bucket limit, so clamped; old entries stay in bucket zero
    write_buckets(11'd2047);
    send_request(1'b0, 32'd0, 64'h1111_2222_3333_4444, 0);
    send_request(1'b1, 32'd0, 64'h9999, 0);
    send_request(1'b1, 32'd5, 64'h7777, 0);                     // may miss now
    send_request(1'b1, 32'd12345, 64'd2, 0);
    end_requests();
    drain();
  endtask

  // receiver held off while probes keep coming, then sender waits for all
  task automatic test_backpressure();
    write_buckets(11'd1);
    hold_req = 1'b1;
    for (int i = 0; i < 16; i++)
      send_request(1'b1, pick_key(), {$urandom(), $urandom()}, 0);
    end_requests();
    drain();
  endtask

  // random phases over several bucket counts, store filling up along the way
  task automatic test_random_mix();
    logic [10:0] counts [6];
    counts = '{11'd1, 11'd4, 11'd1024, 11'd13, 11'd1023, 11'd0};
    for (int p = 0; p < 6; p++) begin
      write_buckets(p == 5 ? 11'($urandom_range(0, 2047)) : counts[p]);
      for (int i = 0; i < 50; i++)
        send_request($urandom_range(0, 99) < 55, pick_key(),
                     {$urandom(), $urandom()}, rand_gap());
      end_requests();
      drain();
    end
  endtask

  // builds past the end of the store
  task automatic test_store_full();
    write_buckets(11'd8);
    while (rows_used < MaxEntries)
      send_request(1'b0, pick_key(), {$urandom(), $urandom()}, rand_gap());
    for (int i = 0; i < 4; i++)
      send_request(1'b0, pick_key(), {$urandom(), $urandom()}, rand_gap());
    send_request(1'b1, 32'd5, 64'hdead_beef, 0);
    end_requests();
    drain();
  endtask

  initial begin
    bucket_reg = 11'd1024;
    rows_used = 0;
    for (int i = 0; i < MaxBuckets; i++) heads[i] = '0;
    for (int i = 0; i < MaxEntries; i++) begin
      stored_keys[i] = '0; stored_words[i] = '0; stored_links[i] = '0;
    end
    errors = 0; cycles = 0; hold_req = 1'b0; hold_left = 0; stall_left = 0;
    n_builds = 0; n_probes = 0; n_matches = 0; n_full = 0; n_nomatch = 0; n_cfg = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_backpressure();
    test_random_mix();
    test_store_full();

    $display("covered %0d builds (%0d refused as full), %0d probes", n_builds, n_full,
             n_probes);
    $display("%0d match rows, %0d no-match results, %0d bucket_total writes",
             n_matches, n_nomatch, n_cfg);
    if (errors == 0) begin
      $display("[hash_join_build_probe] OK");
    end else begin
      $display("[hash_join_build_probe] ERROR");
    end
    $finish;
  end

endmodule
